// File: hw/rtl/udr_pkg.sv
// ----------------------------------------------------------------------------
// udr_pkg
// Shared types and constants of the ultrasonic depth ranger.
// ----------------------------------------------------------------------------
package udr_pkg;

  // Width of the phase tick counter; it saturates at its largest value.
  localparam int COUNT_BITS = 20;
  // Compare width that holds both the counter and the widest limit register.
  localparam int CMP_W = (COUNT_BITS > 20) ? COUNT_BITS : 20;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // Register indexes of the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_PIPE_DEPTH = 3'd0;
  localparam logic [2:0] REG_HALF_SPEED = 3'd1;
  localparam logic [2:0] REG_TIMEOUT    = 3'd2;
  localparam logic [2:0] REG_SETTLE     = 3'd3;
  localparam logic [2:0] REG_TRIGGER    = 3'd4;
  localparam logic [2:0] REG_RETRY_GAP  = 3'd5;
  localparam logic [2:0] REG_MEAS_GAP   = 3'd6;

  // Measurement status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_RISE = 2'd1;
  localparam logic [1:0] ST_NO_FALL = 2'd2;

  // Depth saturation bounds, signed Q8 cm on 20 bits
  localparam logic signed [21:0] DEPTH_MAX = 22'sd262143;
  localparam logic signed [21:0] DEPTH_MIN = -22'sd524288;

  typedef struct packed {
    logic [9:0]  pipe_depth_cm;
    logic [10:0] half_speed_q16;
    logic [15:0] echo_timeout_us;
    logic [7:0]  settle_us;
    logic [7:0]  trigger_us;
    logic [19:0] retry_gap_us;
    logic [19:0] measure_gap_us;
  } cfg_t;

  typedef struct packed {
    logic        trig_level;
    logic        meas_valid;
    logic [1:0]  meas_status;
    logic [15:0] echo_width_us;
  } res_t;

endpackage

// File: hw/rtl/ultrasonic_depth_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_depth_ranger_unit
// Echo ranging controller driven by one microsecond tick per request.
// ----------------------------------------------------------------------------
// Each input request is one microsecond tick with the sampled echo level and
// produces exactly one result carrying the trigger drive level for that tick,
// plus a measurement or timeout report when one completes. A request is held
// in an input register and its result lands in the result register at the next
// edge the output allows. With the output free, one request is taken every
// clock. The input stalls only when both registers are full and the output is
// stalled. The phase update and the 16x11 depth multiply between the two
// registers set the critical path, not the rate. The user must write the
// configuration over the APB port only while the block is idle; the block
// itself does not enforce this.
module ultrasonic_depth_ranger_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [udr_pkg::ADDR_W-1:0]  paddr,
  input  logic [udr_pkg::DATA_W-1:0]  pwdata,
  output logic [udr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_echo_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_trig_level,
  output logic                        out_meas_valid,
  output logic [1:0]                  out_meas_status,
  output logic [15:0]                 out_echo_width_us,
  output logic signed [19:0]          out_depth_q8
);
  import udr_pkg::*;

  cfg_t               cfg;
  res_t               res;
  logic signed [19:0] depth;
  logic               s1_v_r;
  logic               echo_r;
  logic               out_valid_r;
  res_t               res_r;
  logic signed [19:0] depth_r;
  logic               out_free;
  logic               s1_adv;
  logic               in_acc;

  udr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  udr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .echo  (echo_r),
    .cfg   (cfg),
    .res   (res)
  );

  udr_depth u_depth (
    .width    (res.echo_width_us),
    .cfg      (cfg),
    .depth_q8 (depth)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      echo_r <= in_echo_level;
    end
    if (s1_adv) begin
      res_r   <= res;
      // depth reads zero unless a good measurement completes
      depth_r <= (res.meas_valid && res.meas_status == ST_OK) ? depth : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trig_level    = res_r.trig_level;
  assign out_meas_valid    = res_r.meas_valid;
  assign out_meas_status   = res_r.meas_status;
  assign out_echo_width_us = res_r.echo_width_us;
  assign out_depth_q8      = depth_r;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  a_status_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_meas_status != ST_OK) |-> out_meas_valid)
    else $error("error status without a report");

  a_quiet_when_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_meas_valid) |-> (out_echo_width_us == '0 && out_depth_q8 == '0))
    else $error("width or depth set without a report");

  a_no_report_in_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_trig_level) |-> !out_meas_valid)
    else $error("report during trigger pulse");
`endif

endmodule

// File: hw/rtl/udr_cfg.sv
// ----------------------------------------------------------------------------
// udr_cfg
// APB register file holding the ranging configuration.
// ----------------------------------------------------------------------------
module udr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [udr_pkg::ADDR_W-1:0]     paddr,
  input  logic [udr_pkg::DATA_W-1:0]     pwdata,
  output logic [udr_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output udr_pkg::cfg_t                  cfg
);
  import udr_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pipe_depth_cm   <= 10'd250;
      cfg_r.half_speed_q16  <= 11'd1124;
      cfg_r.echo_timeout_us <= 16'd50000;
      cfg_r.settle_us       <= 8'd2;
      cfg_r.trigger_us      <= 8'd10;
      cfg_r.retry_gap_us    <= 20'd100000;
      cfg_r.measure_gap_us  <= 20'd500000;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PIPE_DEPTH: cfg_r.pipe_depth_cm   <= pwdata[9:0];
        REG_HALF_SPEED: cfg_r.half_speed_q16  <= pwdata[10:0];
        REG_TIMEOUT:    cfg_r.echo_timeout_us <= pwdata[15:0];
        REG_SETTLE:     cfg_r.settle_us       <= pwdata[7:0];
        REG_TRIGGER:    cfg_r.trigger_us      <= pwdata[7:0];
        REG_RETRY_GAP:  cfg_r.retry_gap_us    <= pwdata[19:0];
        REG_MEAS_GAP:   cfg_r.measure_gap_us  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PIPE_DEPTH: prdata = DATA_W'(cfg_r.pipe_depth_cm);
      REG_HALF_SPEED: prdata = DATA_W'(cfg_r.half_speed_q16);
      REG_TIMEOUT:    prdata = DATA_W'(cfg_r.echo_timeout_us);
      REG_SETTLE:     prdata = DATA_W'(cfg_r.settle_us);
      REG_TRIGGER:    prdata = DATA_W'(cfg_r.trigger_us);
      REG_RETRY_GAP:  prdata = DATA_W'(cfg_r.retry_gap_us);
      REG_MEAS_GAP:   prdata = DATA_W'(cfg_r.measure_gap_us);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/udr_seq.sv
// ----------------------------------------------------------------------------
// udr_seq
// Phase sequencer: settle, trigger, echo rise wait, echo width, gaps.
// ----------------------------------------------------------------------------
module udr_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          echo,
  input  udr_pkg::cfg_t cfg,
  output udr_pkg::res_t res
);
  import udr_pkg::*;

  typedef enum logic [2:0] {
    PH_SETTLE    = 3'd0,
    PH_TRIG      = 3'd1,
    PH_RISE      = 3'd2,
    PH_FALL      = 3'd3,
    PH_GAP_RETRY = 3'd4,
    PH_GAP_MEAS  = 3'd5
  } phase_t;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      gap_lim;
  logic                  cnt_full;
  logic                  over_timeout;

  function automatic logic reached(input logic [CMP_W-1:0] c, input logic full,
                                   input logic [CMP_W-1:0] lim);
    reached = (c >= lim) || full;
  endfunction

  assign cnt_inc      = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign cnt_ext      = CMP_W'(cnt_inc);
  assign cnt_full     = (cnt_inc == CNT_MAX);
  assign over_timeout = cnt_ext > CMP_W'(cfg.echo_timeout_us);
  assign gap_lim      = (phase_r == PH_GAP_RETRY) ? CMP_W'(cfg.retry_gap_us)
                                                  : CMP_W'(cfg.measure_gap_us);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_inc;
    res       = '0;
    unique case (phase_r)
      PH_SETTLE: begin
        if (reached(cnt_ext, cnt_full, CMP_W'(cfg.settle_us))) begin
          cnt_nxt   = '0;
          phase_nxt = PH_TRIG;
        end
      end
      PH_TRIG: begin
        res.trig_level = 1'b1;
        if (reached(cnt_ext, cnt_full, CMP_W'(cfg.trigger_us))) begin
          cnt_nxt   = '0;
          phase_nxt = PH_RISE;
        end
      end
      PH_RISE: begin
        if (echo) begin
          // rising tick counts as the first high tick
          cnt_nxt   = COUNT_BITS'(1);
          phase_nxt = PH_FALL;
        end else if (over_timeout) begin
          res.meas_valid  = 1'b1;
          res.meas_status = ST_NO_RISE;
          cnt_nxt         = '0;
          phase_nxt       = (cfg.retry_gap_us == '0) ? PH_SETTLE : PH_GAP_RETRY;
        end
      end
      PH_FALL: begin
        if (!echo) begin
          res.meas_valid    = 1'b1;
          res.meas_status   = ST_OK;
          res.echo_width_us = cnt_r[15:0];
          cnt_nxt           = '0;
          phase_nxt         = (cfg.measure_gap_us == '0) ? PH_SETTLE : PH_GAP_MEAS;
        end else if (over_timeout) begin
          res.meas_valid  = 1'b1;
          res.meas_status = ST_NO_FALL;
          cnt_nxt         = '0;
          phase_nxt       = (cfg.retry_gap_us == '0) ? PH_SETTLE : PH_GAP_RETRY;
        end
      end
      PH_GAP_RETRY, PH_GAP_MEAS: begin
        if (reached(cnt_ext, cnt_full, gap_lim)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_SETTLE;
        end
      end
      default: begin
        cnt_nxt   = '0;
        phase_nxt = PH_SETTLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETTLE;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/udr_depth.sv
// ----------------------------------------------------------------------------
// udr_depth
// Depth from echo width: pipe depth minus rounded width times half speed.
// ----------------------------------------------------------------------------
module udr_depth (
  input  logic [15:0]        width,
  input  udr_pkg::cfg_t      cfg,
  output logic signed [19:0] depth_q8
);
  import udr_pkg::*;

  logic [26:0]        prod;
  logic [27:0]        rounded;
  logic [19:0]        travel;
  logic [17:0]        base;
  logic signed [21:0] diff;

  assign prod    = 27'(width) * 27'(cfg.half_speed_q16);
  // round Q16 product to Q8
  assign rounded = 28'(prod) + 28'd128;
  assign travel  = rounded[27:8];
  assign base    = {cfg.pipe_depth_cm, 8'd0};
  assign diff    = $signed({4'd0, base}) - $signed({2'd0, travel});

  always_comb begin
    priority if (diff > DEPTH_MAX) begin
      depth_q8 = DEPTH_MAX[19:0];
    end else if (diff < DEPTH_MIN) begin
      depth_q8 = DEPTH_MIN[19:0];
    end else begin
      depth_q8 = diff[19:0];
    end
  end

endmodule

// File: dv/depth_ranger_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_ranger_checker
// Watches the tick and result channels and the register port of the depth
// ranger. It runs its own model of the trigger/echo cycle, queues the expected
// result of every accepted tick and compares each delivered result field by
// field against the oldest entry.
// ----------------------------------------------------------------------------
module depth_ranger_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [udr_pkg::ADDR_W-1:0] paddr,
  input  logic [udr_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_echo_level,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_trig_level,
  input  logic                       out_meas_valid,
  input  logic [1:0]                 out_meas_status,
  input  logic [15:0]                out_echo_width_us,
  input  logic signed [19:0]         out_depth_q8,
  output int unsigned                pending,
  output int unsigned                mismatches,
  output int unsigned                n_depth,
  output int unsigned                n_no_rise,
  output int unsigned                n_no_fall
);
  import udr_pkg::*;

  typedef enum logic [2:0] {
    PH_SETTLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL,
    PH_RETRY_GAP,
    PH_MEAS_GAP
  } ranger_phase_e;

  typedef struct packed {
    logic        trig;
    logic        meas_valid;
    logic [1:0]  status;
    logic [15:0] width;
    logic [19:0] depth;
  } tick_result_t;

  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

  cfg_t            regs;
  ranger_phase_e   ph;
  longint unsigned ticks;
  tick_result_t    tick_results_q[$];
  int unsigned     n_checked;

  initial begin
    pending    = 0;
    mismatches = 0;
    n_depth    = 0;
    n_no_rise  = 0;
    n_no_fall  = 0;
    n_checked  = 0;
  end

  function automatic longint unsigned bump(input longint unsigned c);
    return (c >= CNT_MAX) ? CNT_MAX : c + 1;
  endfunction

  function automatic bit hit_limit(input longint unsigned c, input longint unsigned lim);
    return (c >= lim) || (c >= CNT_MAX);
  endfunction

  function automatic logic [19:0] depth_from(input logic [15:0] w);
    longint travel;
    longint d;
    // round the travel term to nearest before subtracting
    travel = (longint'(w) * longint'(regs.half_speed_q16) + 128) >>> 8;
    d = longint'(regs.pipe_depth_cm) * 256 - travel;
    if (d > DEPTH_MAX) d = DEPTH_MAX;
    if (d < DEPTH_MIN) d = DEPTH_MIN;
    return d[19:0];
  endfunction

  task automatic start_gap(input ranger_phase_e gap_ph, input longint unsigned gap);
    ticks = 0;
    ph = (gap == 0) ? PH_SETTLE : gap_ph;
  endtask

  task automatic ranger_tick(input logic echo, output tick_result_t r);
    longint unsigned lim;
    r = '0;
    case (ph)
      PH_SETTLE: begin
        ticks = bump(ticks);
        if (hit_limit(ticks, regs.settle_us)) begin
          ticks = 0;
          ph = PH_TRIG;
        end
      end
      PH_TRIG: begin
        r.trig = 1'b1;
        ticks = bump(ticks);
        if (hit_limit(ticks, regs.trigger_us)) begin
          ticks = 0;
          ph = PH_RISE;
        end
      end
      PH_RISE: begin
        if (echo) begin
          // the rising tick is the first high tick
          ticks = 1;
          ph = PH_FALL;
        end else begin
          ticks = bump(ticks);
          if (ticks > regs.echo_timeout_us) begin
            r.meas_valid = 1'b1;
            r.status = ST_NO_RISE;
            start_gap(PH_RETRY_GAP, regs.retry_gap_us);
          end
        end
      end
      PH_FALL: begin
        if (!echo) begin
          r.meas_valid = 1'b1;
          r.status = ST_OK;
          r.width = ticks[15:0];
          r.depth = depth_from(ticks[15:0]);
          start_gap(PH_MEAS_GAP, regs.measure_gap_us);
        end else begin
          ticks = bump(ticks);
          if (ticks > regs.echo_timeout_us) begin
            r.meas_valid = 1'b1;
            r.status = ST_NO_FALL;
            start_gap(PH_RETRY_GAP, regs.retry_gap_us);
          end
        end
      end
      PH_RETRY_GAP, PH_MEAS_GAP: begin
        ticks = bump(ticks);
        lim = (ph == PH_RETRY_GAP) ? regs.retry_gap_us : regs.measure_gap_us;
        if (hit_limit(ticks, lim)) begin
          ticks = 0;
          ph = PH_SETTLE;
        end
      end
      default: begin
        ticks = 0;
        ph = PH_SETTLE;
      end
    endcase
  endtask

  task automatic take_write(input logic [2:0] idx, input logic [DATA_W-1:0] d);
    case (idx)
      REG_PIPE_DEPTH: regs.pipe_depth_cm   = d[9:0];
      REG_HALF_SPEED: regs.half_speed_q16  = d[10:0];
      REG_TIMEOUT:    regs.echo_timeout_us = d[15:0];
      REG_SETTLE:     regs.settle_us       = d[7:0];
      REG_TRIGGER:    regs.trigger_us      = d[7:0];
      REG_RETRY_GAP:  regs.retry_gap_us    = d[19:0];
      REG_MEAS_GAP:   regs.measure_gap_us  = d[19:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $time, n_checked, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      regs = '{pipe_depth_cm: 10'd250, half_speed_q16: 11'd1124,
               echo_timeout_us: 16'd50000, settle_us: 8'd2, trigger_us: 8'd10,
               retry_gap_us: 20'd100000, measure_gap_us: 20'd500000};
      ph    = PH_SETTLE;
      ticks = 0;
      tick_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) take_write(paddr[ADDR_W-1:2], pwdata);
      if (in_valid && !in_stall) begin
        ranger_tick(in_echo_level, want);
        tick_results_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        n_checked++;
        if (tick_results_q.size() == 0) begin
          report_mismatch("result delivered with no tick outstanding");
        end else begin
          want = tick_results_q.pop_front();
          if (out_trig_level !== want.trig)
            report_mismatch($sformatf("trig_level %b, want %b", out_trig_level, want.trig));
          if (out_meas_valid !== want.meas_valid)
            report_mismatch($sformatf("meas_valid %b, want %b",
                                      out_meas_valid, want.meas_valid));
          if (out_meas_status !== want.status)
            report_mismatch($sformatf("meas_status %0d, want %0d",
                                      out_meas_status, want.status));
          if (out_echo_width_us !== want.width)
            report_mismatch($sformatf("echo_width_us %0d, want %0d",
                                      out_echo_width_us, want.width));
          if (out_depth_q8 !== want.depth)
            report_mismatch($sformatf("depth_q8 %0d, want %0d",
                                      out_depth_q8, $signed(want.depth)));
          if (want.meas_valid) begin
            case (want.status)
              ST_OK:      n_depth++;
              ST_NO_RISE: n_no_rise++;
              default:    n_no_fall++;
            endcase
          end
        end
      end
    end
    pending = tick_results_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ultrasonic depth ranger. Feeds echo ticks with
// random gaps and output stalls under a series of register settings, from
// reset values through both extremes, and leaves the checking to the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import udr_pkg::*;

  localparam logic [2:0] REG_UNUSED  = 3'd7;
  localparam int HOLD_AT             = 150;
  localparam int HOLD_CYCLES         = 300;
  localparam int RANDOM_SETTINGS     = 6;
  localparam int TICKS_PER_SETTING   = 20;
  // zero-time settle/trigger, one-tick timeouts both ways, then a short echo
  localparam logic [13:0] EDGE_ECHOES = 14'b00000001100100;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic               in_echo_level;
  logic               out_valid;
  logic               out_stall;
  logic               out_trig_level;
  logic               out_meas_valid;
  logic [1:0]         out_meas_status;
  logic [15:0]        out_echo_width_us;
  logic signed [19:0] out_depth_q8;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned n_depth;
  int unsigned n_no_rise;
  int unsigned n_no_fall;
  int unsigned ticks_sent = 0;
  int unsigned n_settings = 0;
  bit          calm = 1'b0;
  bit          hold_done = 1'b0;
  cfg_t        cur;

  ultrasonic_depth_ranger_unit dut (.*);
  depth_ranger_checker chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) ticks_sent <= ticks_sent + 1;
  end

  initial begin
    #5ms;
    $display("ultrasonic_depth_ranger_unit verification failed");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return lo;
    if (r < 30) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [31:0] pad(input logic [31:0] v, input int w, input bit junk);
    logic [31:0] hi;
    hi = junk ? ($urandom() << w) : 32'd0;
    return v | hi;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.pipe_depth_cm   = 10'(pick(0, 1023));
    c.half_speed_q16  = 11'(pick(0, 2047));
    c.echo_timeout_us = 16'(pick(1, 40));
    c.settle_us       = 8'(pick(0, 6));
    c.trigger_us      = 8'(pick(0, 6));
    c.retry_gap_us    = 20'(pick(0, 30));
    c.measure_gap_us  = 20'(pick(0, 30));
    return c;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c, input bit junk);
    reg_write(REG_PIPE_DEPTH, pad(32'(c.pipe_depth_cm), 10, junk));
    reg_write(REG_HALF_SPEED, pad(32'(c.half_speed_q16), 11, junk));
    reg_write(REG_TIMEOUT,    pad(32'(c.echo_timeout_us), 16, junk));
    reg_write(REG_SETTLE,     pad(32'(c.settle_us), 8, junk));
    reg_write(REG_TRIGGER,    pad(32'(c.trigger_us), 8, junk));
    reg_write(REG_RETRY_GAP,  pad(32'(c.retry_gap_us), 20, junk));
    reg_write(REG_MEAS_GAP,   pad(32'(c.measure_gap_us), 20, junk));
    if (junk) reg_write(REG_UNUSED, $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur = c;
    n_settings++;
  endtask

  // Offer one tick; return at the edge that accepts it, valid still high.
  task automatic send_tick(input logic echo);
    int unsigned gap;
    bit          st;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_echo_level <= echo;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
  endtask

  // Drop valid and wait until every result has been delivered.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly low-then-high echo pulses sized to the current timeout, some noise.
  task automatic run_pulses(input int n_items);
    int sent;
    int lo;
    int hi;
    int span;
    int k;
    sent = 0;
    span = int'(cur.settle_us) + int'(cur.trigger_us) + int'(cur.echo_timeout_us) + 3;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        lo = $urandom_range(0, span);
        hi = $urandom_range(1, int'(cur.echo_timeout_us) + 2);
        repeat (lo) send_tick(1'b0);
        repeat (hi) send_tick(1'b1);
        sent += lo + hi;
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) send_tick(1'($urandom_range(0, 1)));
        sent += k;
      end
    end
  endtask

  initial begin : receiver
    int unsigned n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!hold_done && ticks_sent >= HOLD_AT) begin
        // hold the output long enough for the block to back up its input
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    cfg_t c;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid      <= 1'b0;
    in_echo_level <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: settle and trigger, then a three-tick echo
    repeat (12) send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    wait_quiet();

    c = '{pipe_depth_cm: 10'd0, half_speed_q16: 11'd2047, echo_timeout_us: 16'd1,
          settle_us: 8'd0, trigger_us: 8'd0, retry_gap_us: 20'd0, measure_gap_us: 20'd0};
    load_settings(c, 1'b0);
    for (int i = 13; i >= 0; i--) send_tick(EDGE_ECHOES[i]);
    wait_quiet();

    c = '{pipe_depth_cm: 10'd1023, half_speed_q16: 11'd2047, echo_timeout_us: 16'd65534,
          settle_us: 8'd255, trigger_us: 8'd12, retry_gap_us: 20'd1048575,
          measure_gap_us: 20'd1048575};
    load_settings(c, 1'b1);
    repeat (275) send_tick(1'b0);
    repeat (40) send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    wait_quiet();

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      load_settings(random_settings(), 1'b1);
      calm = ($urandom_range(0, 3) == 0);
      run_pulses(TICKS_PER_SETTING);
      wait_quiet();
    end
    calm = 1'b0;
    repeat (8) @(posedge clk);

    $display("Covered %0d ticks under %0d register settings, with a %0d-cycle output hold",
             ticks_sent, n_settings, HOLD_CYCLES);
    $display("Checked %0d depth readings, %0d no-rise and %0d no-fall timeouts",
             n_depth, n_no_rise, n_no_fall);
    if (mismatches == 0 && pending == 0) begin
      $display("ultrasonic_depth_ranger_unit verification clean");
    end else begin
      $display("ultrasonic_depth_ranger_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/udr_pkg.sv
hw/rtl/udr_cfg.sv
hw/rtl/udr_seq.sv
hw/rtl/udr_depth.sv
hw/rtl/ultrasonic_depth_ranger_unit.sv
dv/depth_ranger_checker.sv
dv/tb_top.sv
